// ----- design/planar_arm_forward_kinematics_top_defines.svh -----
// Assertion macros shared by the planar arm kinematics checker.
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH

// same-cycle implication
`define PFK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pfk_pkg.sv -----
// Types, constants and angle tables for the planar arm kinematics block.
`default_nettype none
package pfk_pkg;

    localparam int TRIG_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 4;
    localparam int CORDIC_STAGES   = 31;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam longint PI_QUARTER_Q30 = 843314857;

    localparam int ANG_W   = 14;
    localparam int LEN_W   = 16;
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
    localparam int ENTRY_W = 16;
    localparam int OFS_W   = 19;
    localparam int ONE     = 1 << TRIG_FRAC_BITS;

    localparam int ANG_HI    = 300 << ANGLE_FRAC_BITS;
    localparam int ANG_MID   = 150 << ANGLE_FRAC_BITS;
    localparam int QUARTER   = 90 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
    localparam int ANG_DIV   = 45 << ANGLE_FRAC_BITS;
    localparam int MAG_W     = $clog2(QUARTER + 1);
    localparam int R_W       = $clog2(ANG_DIV);

    localparam int LANES     = 3;
    localparam int LANE_LAT  = CORDIC_STAGES + 2;
    localparam int MERGE_LAT = 2 * LANES;

    localparam int ATAN_Q30 [CORDIC_STAGES] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2, 1
    };

    typedef enum logic [1:0] {
        REG_BASE_LENGTH       = 2'd0,
        REG_LINK_LENGTH_ONE   = 2'd1,
        REG_LINK_LENGTH_TWO   = 2'd2,
        REG_LINK_LENGTH_THREE = 2'd3
    } reg_idx_t;

    // angle magnitude split as 32*u + v; quotient/remainder of each part by ANG_DIV
    localparam int ZU_N = (QUARTER >> 5) + 1;
    localparam int ZV_N = 32;

    typedef logic [31:0]    zu_q_t [ZU_N];
    typedef logic [R_W-1:0] zu_r_t [ZU_N];
    typedef logic [31:0]    zv_q_t [ZV_N];
    typedef logic [R_W-1:0] zv_r_t [ZV_N];

    function automatic zu_q_t calc_zu_q();
        zu_q_t  t;
        longint p;
        for (int k = 0; k < ZU_N; k++)
        begin
            p = longint'(k) * 32 * PI_QUARTER_Q30;
            t[k] = 32'(p / ANG_DIV);
        end
        return t;
    endfunction

    function automatic zu_r_t calc_zu_r();
        zu_r_t  t;
        longint p;
        for (int k = 0; k < ZU_N; k++)
        begin
            p = longint'(k) * 32 * PI_QUARTER_Q30;
            t[k] = R_W'(p % ANG_DIV);
        end
        return t;
    endfunction

    function automatic zv_q_t calc_zv_q();
        zv_q_t  t;
        longint p;
        for (int k = 0; k < ZV_N; k++)
        begin
            p = longint'(k) * PI_QUARTER_Q30 + ANG_DIV / 2;
            t[k] = 32'(p / ANG_DIV);
        end
        return t;
    endfunction

    function automatic zv_r_t calc_zv_r();
        zv_r_t  t;
        longint p;
        for (int k = 0; k < ZV_N; k++)
        begin
            p = longint'(k) * PI_QUARTER_Q30 + ANG_DIV / 2;
            t[k] = R_W'(p % ANG_DIV);
        end
        return t;
    endfunction

    localparam zu_q_t ZU_Q = calc_zu_q();
    localparam zu_r_t ZU_R = calc_zu_r();
    localparam zv_q_t ZV_Q = calc_zv_q();
    localparam zv_r_t ZV_R = calc_zv_r();

endpackage
`default_nettype wire

// ----- design/pfk_if.sv -----
// Valid/ready request channels for joint angles and pose results.
`default_nettype none
interface pfk_in_if;
    import pfk_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] joint_one_angle;
    logic signed [ANG_W-1:0] joint_two_angle;
    logic signed [ANG_W-1:0] joint_three_angle;

    modport source (output valid, joint_one_angle, joint_two_angle, joint_three_angle,
                    input ready);
    modport sink (input valid, joint_one_angle, joint_two_angle, joint_three_angle,
                  output ready);
endinterface

interface pfk_out_if;
    import pfk_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ENTRY_W-1:0] entry_row0_col0;
    logic signed [ENTRY_W-1:0] entry_row0_col1;
    logic signed [OFS_W-1:0]   offset_x;
    logic signed [ENTRY_W-1:0] entry_row1_col0;
    logic signed [ENTRY_W-1:0] entry_row1_col1;
    logic signed [OFS_W-1:0]   offset_y;

    modport source (output valid, entry_row0_col0, entry_row0_col1, offset_x,
                    entry_row1_col0, entry_row1_col1, offset_y, input ready);
    modport sink (input valid, entry_row0_col0, entry_row0_col1, offset_x,
                  entry_row1_col0, entry_row1_col1, offset_y, output ready);
endinterface
`default_nettype wire

// ----- design/planar_arm_forward_kinematics_top.sv -----
// Top level of the planar three-link arm forward kinematics block.
// Usage:
//   joint_in carries a request of three servo angles (1/16 degree);
//   pose_out returns one request per input: the 2x3 upper part of the
//   chain transform (rotation in Q1.14, offsets in Q10.8, saturated).
//   Link lengths are written through cfg_wr_en/cfg_index/cfg_data while
//   no request is in flight.
//   Three lanes, one per joint, run a 31-stage pipelined CORDIC each; a
//   six-stage chain multiplier then combines base and joint transforms.
//   Throughput: one request per cycle while pose_out does not stall; the
//   CORDIC and chain pipelines take a new request every enabled cycle.
//   Reset clears all valid flags and loads the default link lengths.
//   When pose_out stalls, the whole pipeline holds and joint_in.ready
//   drops; nothing is lost or repeated.
`default_nettype none
module planar_arm_forward_kinematics_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    pfk_in_if.sink                            joint_in,
    pfk_out_if.source                         pose_out,
    input  wire logic                         cfg_wr_en,
    input  wire pfk_pkg::reg_idx_t            cfg_index,
    input  wire logic [pfk_pkg::LEN_W-1:0]    cfg_data
);
    import pfk_pkg::*;

    localparam int LAT = LANE_LAT + MERGE_LAT;

    logic [LEN_W-1:0] base_length_reg;
    logic [LEN_W-1:0] link_length_reg [LANES];
    logic [LAT-1:0]   vld_reg;
    logic             out_valid_reg;
    logic             en;

    logic signed [ANG_W-1:0]  angles [LANES];
    logic signed [TRIG_W-1:0] cos_val [LANES];
    logic signed [TRIG_W-1:0] sin_val [LANES];
    logic signed [17:0]       rot [2][2];
    logic signed [20:0]       trans [2];

    logic signed [ENTRY_W-1:0] e00_reg, e01_reg, e10_reg, e11_reg;
    logic signed [OFS_W-1:0]   ox_reg, oy_reg;

    assign en = !out_valid_reg || pose_out.ready;
    assign joint_in.ready = en && rst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg    <= LEN_W'(1152);
            link_length_reg[0] <= LEN_W'(2432);
            link_length_reg[1] <= LEN_W'(2509);
            link_length_reg[2] <= LEN_W'(1536);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BASE_LENGTH:       base_length_reg    <= cfg_data;
                REG_LINK_LENGTH_ONE:   link_length_reg[0] <= cfg_data;
                REG_LINK_LENGTH_TWO:   link_length_reg[1] <= cfg_data;
                REG_LINK_LENGTH_THREE: link_length_reg[2] <= cfg_data;
                default:               base_length_reg    <= base_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], joint_in.valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    assign angles[0] = joint_in.joint_one_angle;
    assign angles[1] = joint_in.joint_two_angle;
    assign angles[2] = joint_in.joint_three_angle;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        pfk_lane u_lane (
            .clk     (clk),
            .en      (en),
            .angle   (angles[k]),
            .cos_val (cos_val[k]),
            .sin_val (sin_val[k])
        );
    end

    pfk_merge u_merge (
        .clk         (clk),
        .en          (en),
        .cos_val     (cos_val),
        .sin_val     (sin_val),
        .base_length (base_length_reg),
        .link_length (link_length_reg),
        .rot         (rot),
        .trans       (trans)
    );

    function automatic logic signed [ENTRY_W-1:0] clamp_rot(input logic signed [17:0] v);
        if (v > ONE)
            return ENTRY_W'(ONE);
        else if (v < -ONE)
            return -ENTRY_W'(ONE);
        return ENTRY_W'(v);
    endfunction

    function automatic logic signed [OFS_W-1:0] clamp_ofs(input logic signed [20:0] v);
        if (v > 21'sd262143)
            return OFS_W'(262143);
        else if (v < -21'sd262144)
            return OFS_W'(-262144);
        return OFS_W'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e00_reg <= clamp_rot(rot[0][0]);
            e01_reg <= clamp_rot(rot[0][1]);
            e10_reg <= clamp_rot(rot[1][0]);
            e11_reg <= clamp_rot(rot[1][1]);
            ox_reg  <= clamp_ofs(trans[0]);
            oy_reg  <= clamp_ofs(trans[1]);
        end
    end

    assign pose_out.valid           = out_valid_reg;
    assign pose_out.entry_row0_col0 = e00_reg;
    assign pose_out.entry_row0_col1 = e01_reg;
    assign pose_out.entry_row1_col0 = e10_reg;
    assign pose_out.entry_row1_col1 = e11_reg;
    assign pose_out.offset_x        = ox_reg;
    assign pose_out.offset_y        = oy_reg;

endmodule
`default_nettype wire

// ----- design/pfk_lane.sv -----
// One joint lane: angle reduction and pipelined CORDIC giving cosine and sine.
`default_nettype none
module pfk_lane (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [pfk_pkg::ANG_W-1:0] angle,
    output logic signed [pfk_pkg::TRIG_W-1:0]     cos_val,
    output logic signed [pfk_pkg::TRIG_W-1:0]     sin_val
);
    import pfk_pkg::*;

    localparam int CW     = 33;
    localparam int RND_SH = 30 - TRIG_FRAC_BITS;
    localparam int FLUSH_LIM = (ONE + 999) / 1000;

    typedef logic signed [ANG_W:0] ang_t;

    ang_t                clamped;
    ang_t                shifted;
    ang_t                reduced;
    logic                neg;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-6:0]    u_idx;
    logic [4:0]          v_idx;
    logic [R_W:0]        rem_sum;
    logic signed [CW-1:0] z_mag;
    logic signed [CW-1:0] z_start;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES+1];
    logic                 neg_reg [CORDIC_STAGES+1];

    always_comb
    begin
        if (angle < 0)
            clamped = '0;
        else if (angle > ANG_HI)
            clamped = ang_t'(ANG_HI);
        else
            clamped = ang_t'(angle);
        shifted = clamped - ang_t'(ANG_MID);
        if (shifted > QUARTER)
        begin
            reduced = shifted - ang_t'(HALF_TURN);
            neg = 1'b1;
        end
        else if (shifted < -QUARTER)
        begin
            reduced = shifted + ang_t'(HALF_TURN);
            neg = 1'b1;
        end
        else
        begin
            reduced = shifted;
            neg = 1'b0;
        end
        mag = (reduced < 0) ? MAG_W'(-reduced) : MAG_W'(reduced);
        u_idx = mag[MAG_W-1:5];
        v_idx = mag[4:0];
        rem_sum = {1'b0, ZU_R[u_idx]} + {1'b0, ZV_R[v_idx]};
        z_mag = CW'({1'b0, ZU_Q[u_idx]}) + CW'({1'b0, ZV_Q[v_idx]})
              + ((rem_sum >= (R_W+1)'(ANG_DIV)) ? CW'(1) : CW'(0));
        z_start = (reduced < 0) ? -z_mag : z_mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CW'(CORDIC_GAIN_Q30);
            y_reg[0]   <= '0;
            z_reg[0]   <= z_start;
            neg_reg[0] <= neg;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - CW'(ATAN_Q30[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + CW'(ATAN_Q30[i]);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    function automatic logic signed [TRIG_W-1:0] trig_round(
        input logic signed [CW-1:0] v, input logic flip);
        logic signed [CW:0] n;
        logic signed [CW:0] r;
        n = flip ? -(CW+1)'(v) : (CW+1)'(v);
        r = (n + (CW+1)'(1 << (RND_SH - 1))) >>> RND_SH;
        if (r > ONE)
            r = (CW+1)'(ONE);
        else if (r < -ONE)
            r = -(CW+1)'(ONE);
        if (r < FLUSH_LIM && r > -FLUSH_LIM)
            r = '0;
        return TRIG_W'(r);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_val <= trig_round(x_reg[CORDIC_STAGES], neg_reg[CORDIC_STAGES]);
            sin_val <= trig_round(y_reg[CORDIC_STAGES], neg_reg[CORDIC_STAGES]);
        end
    end

endmodule
`default_nettype wire

// ----- design/pfk_merge.sv -----
// Chain product of base and joint transforms from the lane results.
`default_nettype none
module pfk_merge (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [pfk_pkg::TRIG_W-1:0] cos_val [pfk_pkg::LANES],
    input  wire logic signed [pfk_pkg::TRIG_W-1:0] sin_val [pfk_pkg::LANES],
    input  wire logic [pfk_pkg::LEN_W-1:0]         base_length,
    input  wire logic [pfk_pkg::LEN_W-1:0]         link_length [pfk_pkg::LANES],
    output logic signed [17:0]                     rot [2][2],
    output logic signed [20:0]                     trans [2]
);
    import pfk_pkg::*;

    localparam int RW  = 18;
    localparam int TW  = 21;
    localparam int PW  = RW + TRIG_W;
    localparam int PTW = RW + LEN_W + 1;
    localparam int HALF = 1 << (TRIG_FRAC_BITS - 1);

    logic signed [RW-1:0]     r_in  [LANES+1][2][2];
    logic signed [TW-1:0]     t_in  [LANES+1][2];
    logic signed [TRIG_W-1:0] c_in  [LANES+1][LANES];
    logic signed [TRIG_W-1:0] s_in  [LANES+1][LANES];

    assign r_in[0][0][0] = RW'(ONE);
    assign r_in[0][0][1] = '0;
    assign r_in[0][1][0] = '0;
    assign r_in[0][1][1] = RW'(ONE);
    assign t_in[0][0] = '0;
    assign t_in[0][1] = TW'({1'b0, base_length});
    assign c_in[0] = cos_val;
    assign s_in[0] = sin_val;

    for (genvar k = 0; k < LANES; k++)
    begin : g_step
        logic signed [TRIG_W-1:0] bm [2][2];
        logic signed [LEN_W:0]    d;
        logic signed [PW-1:0]     pa_reg [2][2];
        logic signed [PW-1:0]     pb_reg [2][2];
        logic signed [PTW-1:0]    pt_reg [2];
        logic signed [TW-1:0]     ta_reg [2];
        logic signed [TRIG_W-1:0] ca_reg [LANES];
        logic signed [TRIG_W-1:0] sa_reg [LANES];
        logic signed [RW-1:0]     rb_reg [2][2];
        logic signed [TW-1:0]     tb_reg [2];
        logic signed [TRIG_W-1:0] cb_reg [LANES];
        logic signed [TRIG_W-1:0] sb_reg [LANES];

        always_comb
        begin
            bm[0][0] = c_in[k][k];
            bm[0][1] = -s_in[k][k];
            bm[1][0] = s_in[k][k];
            bm[1][1] = c_in[k][k];
            d = (LEN_W+1)'({1'b0, link_length[k]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    for (int j = 0; j < 2; j++)
                    begin
                        pa_reg[i][j] <= PW'(r_in[k][i][0] * bm[0][j]);
                        pb_reg[i][j] <= PW'(r_in[k][i][1] * bm[1][j]);
                    end
                    pt_reg[i] <= PTW'(r_in[k][i][1] * d);
                    ta_reg[i] <= t_in[k][i];
                end
                ca_reg <= c_in[k];
                sa_reg <= s_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    for (int j = 0; j < 2; j++)
                        rb_reg[i][j] <= RW'(((PW+1)'(pa_reg[i][j]) + (PW+1)'(pb_reg[i][j])
                                             + (PW+1)'(HALF)) >>> TRIG_FRAC_BITS);
                    tb_reg[i] <= ta_reg[i]
                               + TW'((pt_reg[i] + PTW'(HALF)) >>> TRIG_FRAC_BITS);
                end
                cb_reg <= ca_reg;
                sb_reg <= sa_reg;
            end
        end

        assign r_in[k+1] = rb_reg;
        assign t_in[k+1] = tb_reg;
        assign c_in[k+1] = cb_reg;
        assign s_in[k+1] = sb_reg;
    end

    assign rot   = r_in[LANES];
    assign trans = t_in[LANES];

endmodule
`default_nettype wire

// ----- design/pfk_checker.sv -----
// Port-level assertions for the planar arm kinematics top and its bind.
`default_nettype none
`include "planar_arm_forward_kinematics_top_defines.svh"
module pfk_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] e00,
    input wire logic signed [15:0] e11,
    input wire logic signed [18:0] ox
);
    `PFK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `PFK_ASSERT_NEXT(a_ofs_stable, out_valid && !out_ready, $stable(ox), "stalled offset moved")
    `PFK_ASSERT_NOW(a_no_take_on_stall, out_valid && !out_ready, !in_ready, "took input on stall")
    `PFK_ASSERT_NOW(a_rot_range, out_valid,
        e00 <= 16'sd16384 && e00 >= -16'sd16384 && e11 <= 16'sd16384 && e11 >= -16'sd16384,
        "rotation out of range")
endmodule

bind planar_arm_forward_kinematics_top pfk_checker u_pfk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (joint_in.ready),
    .out_valid (pose_out.valid),
    .out_ready (pose_out.ready),
    .e00       (pose_out.entry_row0_col0),
    .e11       (pose_out.entry_row1_col1),
    .ox        (pose_out.offset_x)
);
`default_nettype wire
